@@ src/binary_weight_dense_neuron_defines.svh @@
// Assertion macros used by the binary weight dense neuron controller.
`ifndef BINARY_WEIGHT_DENSE_NEURON_DEFINES_SVH
`define BINARY_WEIGHT_DENSE_NEURON_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BWDN_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BWDN_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bwdn_pkg.sv @@
// Types, constants and helper functions of the binary weight dense neuron.
package bwdn_pkg;

  localparam int ACT_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF = 32;
  localparam int FRAC_BITS     = 8;
  localparam int MODE_W        = 2;
  localparam int PROD_W        = 49;

  localparam logic [MODE_W-1:0] MODE_SUM   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NORM  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BIN   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_BIN;

  localparam logic signed [31:0] ONE_POS = 32'sd256;
  localparam logic signed [31:0] ONE_NEG = -32'sd256;
  localparam logic signed [63:0] SAT_HI  = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO  = -64'sd2147483648;

  typedef enum logic [3:0] {
    DP_IDLE = 4'd0,
    DP_ACC  = 4'd1,
    DP_BIAS = 4'd2,
    DP_SUB  = 4'd3,
    DP_MUL1 = 4'd4,
    DP_FIX1 = 4'd5,
    DP_MUL2 = 4'd6,
    DP_FIX2 = 4'd7,
    DP_BETA = 4'd8,
    DP_LOAD = 4'd9
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic              last;
    logic [MODE_W-1:0] mode;
  } bwdn_cmd_t;

  typedef struct packed {
    logic              hit;
    logic signed [31:0] val;
  } clip_t;

  function automatic clip_t sat32(input logic signed [63:0] x);
    clip_t r;
    r.hit = 1'b1;
    if (x > SAT_HI) begin
      r.val = 32'sh7fffffff;
    end else if (x < SAT_LO) begin
      r.val = 32'sh80000000;
    end else begin
      r.hit = 1'b0;
      r.val = x[31:0];
    end
    return r;
  endfunction

endpackage

@@ src/bwdn_ctrl.sv @@
// Controller state machine and mode register of the binary weight dense neuron.
`include "binary_weight_dense_neuron_defines.svh"

module bwdn_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tlast,
  output logic                      in_tready,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic                      cfg_valid,
  input  logic [bwdn_pkg::MODE_W-1:0] cfg_data,
  output logic                      cfg_ready,
  output bwdn_pkg::bwdn_cmd_t       cmd
);
  import bwdn_pkg::*;

  typedef enum logic [8:0] {
    S_ACC  = 9'b000000001,
    S_BIAS = 9'b000000010,
    S_SUB  = 9'b000000100,
    S_MUL1 = 9'b000001000,
    S_FIX1 = 9'b000010000,
    S_MUL2 = 9'b000100000,
    S_FIX2 = 9'b001000000,
    S_BETA = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;
  logic              can_load;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_ACC);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign can_load   = !out_valid_r || out_tready;

  always_comb begin
    mode_nxt = cfg_valid ? cfg_data : mode_r;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.op        = DP_IDLE;
    cmd.last      = in_tlast;
    cmd.mode      = mode_r;
    unique case (state_r)
      S_ACC: begin
        if (accept) begin
          cmd.op = DP_ACC;
          if (in_tlast) begin
            state_nxt = S_BIAS;
          end
        end
      end
      S_BIAS: begin
        cmd.op    = DP_BIAS;
        state_nxt = (mode_r == MODE_SUM) ? S_DONE : S_SUB;
      end
      S_SUB: begin
        cmd.op    = DP_SUB;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.op    = DP_MUL1;
        state_nxt = S_FIX1;
      end
      S_FIX1: begin
        cmd.op    = DP_FIX1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.op    = DP_MUL2;
        state_nxt = S_FIX2;
      end
      S_FIX2: begin
        cmd.op    = DP_FIX2;
        state_nxt = S_BETA;
      end
      S_BETA: begin
        cmd.op    = DP_BETA;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (can_load) begin
          cmd.op        = DP_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      mode_r      <= MODE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `BWDN_ASSERT_NEXT(a_last_starts_tail, accept && in_tlast, state_r == S_BIAS, "tail not started")
  `BWDN_ASSERT_NEXT(a_sum_mode_skips, (state_r == S_BIAS) && (mode_r == MODE_SUM), state_r == S_DONE, "mode zero did not skip normalization")
  `BWDN_ASSERT_NEXT(a_load_shows, (state_r == S_DONE) && can_load, out_valid_r && (state_r == S_ACC), "result not presented")
  `BWDN_ASSERT_NOW(a_no_input_in_tail, out_valid_r && (state_r == S_DONE), !in_tready, "input taken while result pending")

endmodule

@@ src/bwdn_datapath.sv @@
// Accumulator, normalization arithmetic and output register of the neuron.
module bwdn_datapath #(
  parameter int ACT_WIDTH = bwdn_pkg::ACT_WIDTH_DEF,
  parameter int ACC_WIDTH = bwdn_pkg::ACC_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bwdn_pkg::bwdn_cmd_t         cmd,
  input  logic signed [ACT_WIDTH-1:0] activation,
  input  logic                        weight_negative,
  input  logic signed [15:0]          bias,
  input  logic signed [31:0]          norm_mean,
  input  logic [15:0]                 norm_inv_std,
  input  logic signed [15:0]          norm_gain,
  input  logic signed [31:0]          norm_shift,
  output logic signed [31:0]          neuron_value,
  output logic                        binary_negative,
  output logic                        saturated
);
  import bwdn_pkg::*;

  localparam int SW = ((ACC_WIDTH > ACT_WIDTH) ? ACC_WIDTH : ACT_WIDTH) + 1;
  localparam logic signed [SW-1:0] ACC_HI = SW'({1'b0, {(ACC_WIDTH-1){1'b1}}});
  localparam logic signed [SW-1:0] ACC_LO = ~ACC_HI;

  logic signed [ACC_WIDTH-1:0] sum_r, sum_nxt;
  logic                        clip_r, clip_nxt;
  logic signed [31:0]          val_r, val_nxt;
  logic                        sat_r, sat_nxt;
  logic signed [PROD_W-1:0]    prod_r, prod_nxt;
  logic signed [15:0]          bias_r;
  logic signed [31:0]          mean_r;
  logic [15:0]                 inv_r;
  logic signed [15:0]          gain_r;
  logic signed [31:0]          beta_r;
  logic signed [31:0]          out_val_r;
  logic                        out_bin_r;
  logic                        out_sat_r;

  logic signed [SW-1:0]        sum_ext, act_ext, acc_raw;
  logic signed [ACC_WIDTH-1:0] acc_clip;
  logic                        acc_hit;
  logic signed [16:0]          mul_b;
  logic signed [PROD_W-1:0]    mul_res;
  logic signed [PROD_W-1:0]    prod_sh;
  clip_t                       stage;

  always_comb begin
    sum_ext = SW'(sum_r);
    act_ext = SW'(activation);
    acc_raw = weight_negative ? (sum_ext - act_ext) : (sum_ext + act_ext);
    acc_hit = 1'b1;
    if (acc_raw > ACC_HI) begin
      acc_clip = ACC_HI[ACC_WIDTH-1:0];
    end else if (acc_raw < ACC_LO) begin
      acc_clip = ACC_LO[ACC_WIDTH-1:0];
    end else begin
      acc_hit  = 1'b0;
      acc_clip = acc_raw[ACC_WIDTH-1:0];
    end
  end

  assign mul_b   = (cmd.op == DP_MUL1) ? $signed({1'b0, inv_r}) : 17'(gain_r);
  assign mul_res = val_r * mul_b;
  assign prod_sh = prod_r >>> FRAC_BITS;

  always_comb begin
    sum_nxt  = sum_r;
    clip_nxt = clip_r;
    val_nxt  = val_r;
    sat_nxt  = sat_r;
    prod_nxt = prod_r;
    stage    = sat32(64'(prod_sh));
    unique case (cmd.op)
      DP_IDLE, DP_LOAD: begin
      end
      DP_ACC: begin
        sum_nxt  = acc_clip;
        clip_nxt = clip_r | acc_hit;
      end
      DP_BIAS: begin
        stage    = sat32(64'(sum_r) + 64'(bias_r));
        val_nxt  = stage.val;
        sat_nxt  = clip_r | stage.hit;
        sum_nxt  = '0;
        clip_nxt = 1'b0;
      end
      DP_SUB: begin
        stage   = sat32(64'(val_r) - 64'(mean_r));
        val_nxt = stage.val;
        sat_nxt = sat_r | stage.hit;
      end
      DP_MUL1, DP_MUL2: begin
        prod_nxt = mul_res;
      end
      DP_FIX1, DP_FIX2: begin
        val_nxt = stage.val;
        sat_nxt = sat_r | stage.hit;
      end
      DP_BETA: begin
        stage   = sat32(64'(val_r) + 64'(beta_r));
        val_nxt = stage.val;
        sat_nxt = sat_r | stage.hit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      clip_r <= 1'b0;
    end else begin
      sum_r  <= sum_nxt;
      clip_r <= clip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    sat_r  <= sat_nxt;
    prod_r <= prod_nxt;
    if (cmd.op == DP_ACC && cmd.last) begin
      bias_r <= bias;
      mean_r <= norm_mean;
      inv_r  <= norm_inv_std;
      gain_r <= norm_gain;
      beta_r <= norm_shift;
    end
    if (cmd.op == DP_LOAD) begin
      out_sat_r <= sat_r;
      if (cmd.mode[1]) begin
        out_bin_r <= val_r[31];
        out_val_r <= val_r[31] ? ONE_NEG : ONE_POS;
      end else begin
        out_bin_r <= 1'b0;
        out_val_r <= val_r;
      end
    end
  end

  assign neuron_value    = out_val_r;
  assign binary_negative = out_bin_r;
  assign saturated       = out_sat_r;

endmodule

@@ src/binary_weight_dense_neuron.sv @@
// Top level of the binary weight dense neuron: stream ports, controller and datapath.
// Each request carries one activation and the sign of its weight; requests that are not
// marked last are taken one per clock cycle and added or subtracted into a saturating
// accumulator. The request marked last starts the result tail, during which in_tready is
// low. In output mode 0 the bias add and the result load run; in modes 1 to 3 the bias
// add, mean subtraction, two multiplications through one shared 32 by 17 bit multiplier,
// each followed by a fraction drop and clip step, the beta add and the result load run
// in turn. The tail holds in its final state while an earlier result has not been taken.
// The output register then frees the input side, so accumulation of the next neuron
// proceeds while the result waits. Writes to the mode register are always taken.
module binary_weight_dense_neuron #(
  parameter int ACT_WIDTH = bwdn_pkg::ACT_WIDTH_DEF,
  parameter int ACC_WIDTH = bwdn_pkg::ACC_WIDTH_DEF,
  localparam int IN_DATA_W = ((ACT_WIDTH + 112 + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // activation, bias, norm_mean, norm_inv_std, norm_gain, norm_shift, zero pad
  input  logic [IN_DATA_W-1:0]      in_tdata,
  // weight_negative
  input  logic                      in_tuser,
  input  logic                      in_tlast,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // neuron_value
  output logic [31:0]               out_tdata,
  // binary_negative, saturated
  output logic [1:0]                out_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bwdn_pkg::MODE_W-1:0] cfg_data
);
  import bwdn_pkg::*;

  bwdn_cmd_t                 cmd;
  logic signed [ACT_WIDTH-1:0] activation;
  logic signed [15:0]        bias;
  logic signed [31:0]        norm_mean;
  logic [15:0]               norm_inv_std;
  logic signed [15:0]        norm_gain;
  logic signed [31:0]        norm_shift;
  logic signed [31:0]        neuron_value;
  logic                      binary_negative;
  logic                      saturated;

  assign activation   = in_tdata[ACT_WIDTH-1:0];
  assign bias         = in_tdata[ACT_WIDTH +: 16];
  assign norm_mean    = in_tdata[ACT_WIDTH+16 +: 32];
  assign norm_inv_std = in_tdata[ACT_WIDTH+48 +: 16];
  assign norm_gain    = in_tdata[ACT_WIDTH+64 +: 16];
  assign norm_shift   = in_tdata[ACT_WIDTH+80 +: 32];

  bwdn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cfg_ready  (cfg_ready),
    .cmd        (cmd)
  );

  bwdn_datapath #(
    .ACT_WIDTH (ACT_WIDTH),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .activation      (activation),
    .weight_negative (in_tuser),
    .bias            (bias),
    .norm_mean       (norm_mean),
    .norm_inv_std    (norm_inv_std),
    .norm_gain       (norm_gain),
    .norm_shift      (norm_shift),
    .neuron_value    (neuron_value),
    .binary_negative (binary_negative),
    .saturated       (saturated)
  );

  assign out_tdata = neuron_value;
  assign out_tuser = {saturated, binary_negative};

endmodule

@@ tb/bwdn_checker.sv @@
// Checker that predicts and compares every neuron result of the binary weight dense neuron.
module bwdn_checker
  import bwdn_pkg::*;
#(
  parameter int IN_W = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IN_W-1:0]   in_tdata,
  input  logic              in_tuser,
  input  logic              in_tlast,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [31:0]       out_tdata,
  input  logic [1:0]        out_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [MODE_W-1:0] cfg_data,
  output int                fail_count,
  output int                pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] value;
    logic               bin_neg;
    logic               sat;
  } neuron_result_t;

  neuron_result_t     expected_neurons[$];
  logic signed [31:0] acc_sum;
  logic               acc_clipped;
  logic [MODE_W-1:0]  active_mode;

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  task automatic accumulate_request(input logic [IN_W-1:0] d, input logic wneg,
                                    input logic lst);
    longint         act;
    longint         raw;
    longint         v;
    logic           sat;
    neuron_result_t r;
    act = longint'($signed(d[15:0]));
    raw = wneg ? longint'(acc_sum) - act : longint'(acc_sum) + act;
    v = clamp32(raw);
    if (v != raw) acc_clipped = 1'b1;
    acc_sum = 32'(v);
    if (lst) begin
      sat = acc_clipped;
      r.bin_neg = 1'b0;
      raw = v + longint'($signed(d[31:16]));
      v = clamp32(raw);
      if (v != raw) sat = 1'b1;
      if (active_mode != MODE_SUM) begin
        raw = v - longint'($signed(d[63:32]));
        v = clamp32(raw);
        if (v != raw) sat = 1'b1;
        raw = (v * longint'(d[79:64])) >>> FRAC_BITS;
        v = clamp32(raw);
        if (v != raw) sat = 1'b1;
        raw = (v * longint'($signed(d[95:80]))) >>> FRAC_BITS;
        v = clamp32(raw);
        if (v != raw) sat = 1'b1;
        raw = v + longint'($signed(d[127:96]));
        v = clamp32(raw);
        if (v != raw) sat = 1'b1;
        if (active_mode >= MODE_BIN) begin
          r.bin_neg = (v < 0);
          v = r.bin_neg ? longint'(ONE_NEG) : longint'(ONE_POS);
        end
      end
      r.value = 32'(v);
      r.sat = sat;
      expected_neurons.push_back(r);
      acc_sum = '0;
      acc_clipped = 1'b0;
    end
  endtask

  task automatic compare_neuron();
    neuron_result_t r;
    if (expected_neurons.size() == 0) begin
      $display("%0t: unexpected result value=%0d user=%b", $time, $signed(out_tdata),
               out_tuser);
      fail_count++;
    end else begin
      r = expected_neurons.pop_front();
      if (out_tdata !== r.value) begin
        $display("%0t: neuron_value mismatch expected=%0d actual=%0d", $time, r.value,
                 $signed(out_tdata));
        fail_count++;
      end
      if (out_tuser[0] !== r.bin_neg) begin
        $display("%0t: binary_negative mismatch expected=%b actual=%b", $time, r.bin_neg,
                 out_tuser[0]);
        fail_count++;
      end
      if (out_tuser[1] !== r.sat) begin
        $display("%0t: saturated mismatch expected=%b actual=%b", $time, r.sat,
                 out_tuser[1]);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      acc_sum = '0;
      acc_clipped = 1'b0;
      active_mode = MODE_RESET;
      expected_neurons.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) active_mode = cfg_data;
      if (in_tvalid && in_tready) accumulate_request(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) compare_neuron();
    end
    pending_results <= expected_neurons.size();
  end

endmodule

@@ tb/tb_binary_weight_dense_neuron.sv @@
// Testbench top that drives requests and mode writes into the binary weight dense neuron.
module tb_binary_weight_dense_neuron;
  timeunit 1ns;
  timeprecision 1ps;
  import bwdn_pkg::*;

  localparam int IN_W = ((ACT_WIDTH_DEF + 112 + 7) / 8) * 8;
  localparam logic [MODE_W-1:0] MODE_BIN_ALT = 2'd3;
  localparam logic [15:0] UNIT = 16'h0100;
  localparam logic [15:0] HALF = 16'h0080;
  localparam int TAIL_PAUSE = 16;
  localparam int DRAIN_LIMIT = 5000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 245;

  logic              clk = 1'b0;
  logic              rst_n;
  logic [IN_W-1:0]   in_tdata;
  logic              in_tuser;
  logic              in_tlast;
  logic              in_tvalid;
  logic              in_tready;
  logic [31:0]       out_tdata;
  logic [1:0]        out_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [MODE_W-1:0] cfg_data;
  int                fail_count;
  int                pending_results;
  int                in_idle_pct = 0;
  int                out_idle_pct = 0;
  int                quiet_cycles = 0;

  binary_weight_dense_neuron u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  bwdn_checker #(.IN_W(IN_W)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .in_tlast       (in_tlast),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int pick_gap(input int pct);
    if (pct == 0 || $urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 7) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'($urandom_range(0, 131071) - 65536);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pack_request(input logic [15:0] act, bias,
                                                   input logic [31:0] mean,
                                                   input logic [15:0] istd, gain,
                                                   input logic [31:0] beta);
    return IN_W'({beta, gain, istd, mean, bias, act});
  endfunction

  // Half of the requests carry moderate normalization terms so that the sign varies.
  function automatic logic [IN_W-1:0] random_request(input logic [15:0] act);
    if ($urandom_range(0, 1) == 0) begin
      return pack_request(act, pick16(), 32'($urandom_range(0, 131071) - 65536),
                          16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1023) - 512),
                          32'($urandom_range(0, 131071) - 65536));
    end
    return pack_request(act, pick16(), pick32(), pick16(), pick16(), pick32());
  endfunction

  task automatic send_request(input logic [IN_W-1:0] data, input logic wneg,
                              input logic lst);
    int gap;
    gap = pick_gap(in_idle_pct);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= data;
    in_tuser <= wneg;
    in_tlast <= lst;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (TAIL_PAUSE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_neurons(input int n_items);
    int count;
    int len;
    count = 0;
    while (count < n_items) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        send_request(random_request(pick16()), 1'($urandom_range(0, 1)), i == len - 1);
        count++;
      end
    end
  endtask

  initial begin
    int gap;
    int hold;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = pick_gap(out_idle_pct);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      hold = $urandom_range(1, 4);
      repeat (hold) @(posedge clk);
    end
  end

  initial begin
    logic [MODE_W-1:0] phase_mode[5];
    int                phase_in_idle[5];
    int                phase_out_idle[5];
    int                drain;
    phase_mode = '{MODE_BIN, MODE_SUM, MODE_NORM, MODE_BIN_ALT, MODE_BIN};
    phase_in_idle = '{0, 30, 60, 10, 45};
    phase_out_idle = '{40, 0, 60, 20, 10};
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    in_tlast <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= MODE_SUM;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The mode after reset binarizes; zero counts as positive.
    in_idle_pct = 20;
    out_idle_pct = 30;
    send_request(pack_request(16'h7fff, 16'h0000, 32'd0, UNIT, UNIT, 32'd0), 1'b0, 1'b1);
    send_request(pack_request(16'h8000, 16'h0000, 32'd0, UNIT, UNIT, 32'd0), 1'b0, 1'b1);
    send_request(pack_request(16'h0000, 16'h0000, 32'd0, UNIT, UNIT, 32'd0), 1'b1, 1'b1);
    send_request(pack_request(16'h0100, 16'h0000, 32'd0, UNIT, UNIT, 32'd0), 1'b1, 1'b0);
    send_request(pack_request(16'h0001, 16'hffff, 32'd0, UNIT, UNIT, 32'd0), 1'b0, 1'b1);

    write_mode(MODE_SUM);
    send_request(pack_request(16'h7fff, 16'h8000, 32'd0, UNIT, UNIT, 32'd0), 1'b1, 1'b1);
    send_request(pack_request(16'h8000, 16'h7fff, 32'd0, UNIT, UNIT, 32'd0), 1'b1, 1'b1);
    send_request(pack_request(16'h1234, 16'h0000, 32'd0, UNIT, UNIT, 32'd0), 1'b0, 1'b0);
    send_request(pack_request(16'h0421, 16'h0000, 32'd0, UNIT, UNIT, 32'd0), 1'b1, 1'b0);
    send_request(pack_request(16'hff00, 16'h0010, 32'd0, UNIT, UNIT, 32'd0), 1'b0, 1'b1);

    // Each normalization stage clips, and negative products round toward minus infinity.
    write_mode(MODE_NORM);
    send_request(pack_request(16'h7fff, 16'h7fff, 32'h8000_0000, 16'hffff, 16'h8000,
                              32'h8000_0000), 1'b0, 1'b1);
    send_request(pack_request(16'h0000, 16'h0000, 32'h8000_0000, 16'hffff, 16'h7fff,
                              32'h7fff_ffff), 1'b0, 1'b1);
    send_request(pack_request(16'h7fff, 16'h0000, 32'h7fff_ffff, UNIT, UNIT, 32'd0),
                 1'b1, 1'b1);
    send_request(pack_request(16'hffff, 16'h0000, 32'd0, HALF, UNIT, 32'd0), 1'b0, 1'b1);
    send_request(pack_request(16'h0001, 16'h0000, 32'd0, HALF, UNIT, 32'd0), 1'b0, 1'b1);
    send_request(pack_request(16'h7fff, 16'h0000, 32'd0, 16'h0000, UNIT, 32'd5), 1'b0, 1'b1);
    send_request(pack_request(16'h7fff, 16'h0000, 32'd0, UNIT, 16'h8000, 32'h8000_0000),
                 1'b0, 1'b1);
    send_request(pack_request(16'h0300, 16'h0000, 32'h0000_0400, 16'h0180, 16'hff00,
                              32'h0000_0100), 1'b0, 1'b1);

    write_mode(MODE_BIN_ALT);
    send_request(pack_request(16'h1234, 16'h0000, 32'h0000_2000, UNIT, UNIT, 32'd0),
                 1'b1, 1'b1);
    send_request(pack_request(16'h1234, 16'h0000, 32'h0000_1000, UNIT, UNIT, 32'd0),
                 1'b0, 1'b1);

    write_mode(MODE_SUM);
    in_idle_pct = 0;
    out_idle_pct = 20;
    send_request(pack_request(16'h0005, 16'h0003, 32'd0, UNIT, UNIT, 32'd0), 1'b0, 1'b1);

    for (int p = 0; p < 5; p++) begin
      write_mode(phase_mode[p]);
      in_idle_pct = phase_in_idle[p];
      out_idle_pct = phase_out_idle[p];
      run_neurons(PHASE_ITEMS);
    end

    in_tvalid <= 1'b0;
    drain = 0;
    do begin
      @(posedge clk);
      drain++;
    end while (pending_results != 0 && drain < DRAIN_LIMIT);
    repeat (TAIL_PAUSE) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
